// ----- hw/rtl/mp2_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2_pkg
// Shared constants for the 2x2 max pooling stream block.
// ----------------------------------------------------------------------------
package mp2_pkg;

	localparam int DEF_MAX_WIDTH   = 1024;
	localparam int DEF_SAMPLE_BITS = 16;

	localparam int CFG_BITS   = 11;
	localparam int MAX_HEIGHT = 1024;
	localparam int ROW_BITS   = 10;
	localparam int OUT_BITS   = 15;
	localparam int IDX_BITS   = 1;

	localparam logic [IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

endpackage

// ----- hw/rtl/mp2_line_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2_line_store
// Line store of upper-row pair maxima, one write or one registered read a cycle.
// ----------------------------------------------------------------------------
module mp2_line_store import mp2_pkg::*; #(
	parameter int DEPTH     = DEF_MAX_WIDTH / 2,
	parameter int DATA_BITS = DEF_SAMPLE_BITS,
	parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] addr,
	input  logic [DATA_BITS-1:0] wdata,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ----- hw/rtl/max_pool_2x2_stream.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_2x2_stream
// 2x2 stride-2 max pooling over a raster sample stream, results floored at 0.
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one signed sample per transfer, raster order, plane by plane.
//   m_* carries one pooled value per completed 2x2 window; m_tlast marks the
//   last window of a plane. odd right or bottom edges give clipped windows.
//   cfg_we/cfg_index/cfg_data set image_width (0) and image_height (1); a
//   write restarts the current plane. write only while the block is idle.
// throughput and path:
//   one sample per cycle sustained while m_tready stays high. the sample
//   that closes a window is captured with its memory read into the staged
//   result at its own transfer edge, then loads the output register, from
//   which it transfers on m_*. the line store takes at most one access per
//   column pair, either a write on an upper row or a read on a lower row.
// reset:
//   counters clear, width and height return to 1024; the line store is not
//   cleared, each entry is written on the upper row before it is read.
// stall:
//   while m_tready is low the output and one staged result hold; s_tready
//   drops once both are full, nothing is dropped.
// ----------------------------------------------------------------------------
module max_pool_2x2_stream import mp2_pkg::*; #(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [IDX_BITS-1:0]                  cfg_index,
	input  logic [CFG_BITS-1:0]                  cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// sample
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// pooled_value, zero pad
	output logic [((OUT_BITS+7)/8)*8-1:0]        m_tdata,
	// plane_done
	output logic                                 m_tlast
);

	localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int COL_BITS    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int M_BITS      = ((OUT_BITS + 7) / 8) * 8;

	logic [CFG_BITS-1:0] width_q;
	logic [CFG_BITS-1:0] height_q;
	logic [COL_BITS-1:0] col_q;
	logic [ROW_BITS-1:0] row_q;
	logic signed [SAMPLE_BITS-1:0] pair_q;

	logic [COL_BITS-1:0] col_last;
	logic [ROW_BITS-1:0] row_last;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic signed [SAMPLE_BITS-1:0] pair_next;
	logic accept;
	logic last_col;
	logic last_row;
	logic pair_done;
	logic emit;
	logic st_we;
	logic st_re;
	logic [ADDR_BITS-1:0] st_addr;
	logic signed [SAMPLE_BITS-1:0] st_rdata;

	logic s1_v_q;
	logic signed [SAMPLE_BITS-1:0] pair_s1;
	logic use_store_s1;
	logic done_s1;
	logic s1_move;
	logic signed [SAMPLE_BITS-1:0] win_max;
	logic [SAMPLE_BITS-1:0] floored;

	logic out_v_q;
	logic [OUT_BITS-1:0] out_val_q;
	logic out_last_q;

	// clamp dimensions to their legal ranges
	always_comb begin
		if (width_q == '0) begin
			col_last = '0;
		end else if (int'(width_q) > MAX_WIDTH) begin
			col_last = COL_BITS'(MAX_WIDTH - 1);
		end else begin
			col_last = COL_BITS'(width_q - 1'b1);
		end
		if (height_q == '0) begin
			row_last = '0;
		end else if (int'(height_q) > MAX_HEIGHT) begin
			row_last = ROW_BITS'(MAX_HEIGHT - 1);
		end else begin
			row_last = ROW_BITS'(height_q - 1'b1);
		end
	end

	assign sample    = s_tdata[SAMPLE_BITS-1:0];
	assign last_col  = (col_q == col_last);
	assign last_row  = (row_q == row_last);
	assign pair_next = (!col_q[0] || sample > pair_q) ? sample : pair_q;
	assign pair_done = col_q[0] || last_col;
	assign emit      = pair_done && (row_q[0] || last_row);

	assign s1_move  = s1_v_q && (!out_v_q || m_tready);
	assign s_tready = !s1_v_q || s1_move;
	assign accept   = s_tvalid && s_tready;

	assign st_addr = ADDR_BITS'(col_q >> 1);
	assign st_we   = accept && pair_done && !row_q[0] && !last_row;
	assign st_re   = accept && pair_done && row_q[0];

	mp2_line_store #(
		.DEPTH     (STORE_DEPTH),
		.DATA_BITS (SAMPLE_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.re    (st_re),
		.addr  (st_addr),
		.wdata (pair_next),
		.rdata (st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_BITS'(1024);
			height_q <= CFG_BITS'(1024);
			col_q    <= '0;
			row_q    <= '0;
			pair_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					width_q <= cfg_data;
					col_q   <= '0;
					row_q   <= '0;
					pair_q  <= '0;
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data;
					col_q    <= '0;
					row_q    <= '0;
					pair_q   <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			pair_q <= pair_next;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// staged result waiting on the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (accept) begin
			s1_v_q <= emit;
		end else if (s1_move) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pair_s1      <= pair_next;
			use_store_s1 <= row_q[0];
			done_s1      <= last_col && last_row;
		end
	end

	assign win_max = (use_store_s1 && st_rdata > pair_s1) ? st_rdata : pair_s1;
	assign floored = win_max[SAMPLE_BITS-1] ? '0 : win_max;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_move) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_val_q  <= OUT_BITS'(floored);
			out_last_q <= done_s1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = M_BITS'(out_val_q);
	assign m_tlast  = out_last_q;

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)
		|=> col_q == '0 && row_q == '0)
		else $error("config write did not restart the plane");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_we && st_re))
		else $error("line store read and write in one cycle");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && !s1_move
		|=> s1_v_q && $stable(pair_s1) && (!use_store_s1 || $stable(st_rdata)))
		else $error("staged result lost while output stalled");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v_q |-> s_tready)
		else $error("input stalled with empty output");

endmodule

// ----- dv/max_pool_2x2_stream_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_2x2_stream_checker
// Scoreboard for the 2x2 max pooling stream block.
// Watches the config port and both stream channels. Every accepted sample
// runs through a behavioral model of the pooling datapath. The pooled values
// it predicts wait in order and are compared field by field with each output
// transfer. The mismatch count and the number of pending results go back to
// the testbench top.
// ----------------------------------------------------------------------------
module max_pool_2x2_stream_checker import mp2_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [IDX_BITS-1:0]     cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	input  logic                    s_tvalid,
	input  logic                    s_tready,
	input  logic [15:0]             s_tdata,
	input  logic                    m_tvalid,
	input  logic                    m_tready,
	input  logic [15:0]             m_tdata,
	input  logic                    m_tlast,
	output int unsigned             mismatches,
	output int unsigned             awaited
);

	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;

	typedef struct packed {
		logic [OUT_BITS-1:0] value;
		logic                plane_done;
	} pooled_t;

	pooled_t            pooled_q[$];
	logic signed [15:0] pair_line [LINE_DEPTH];
	logic signed [15:0] pair_peak;
	int unsigned        col_idx;
	int unsigned        row_idx;
	logic [CFG_BITS-1:0] width_reg;
	logic [CFG_BITS-1:0] height_reg;
	int unsigned        err_count;

	function automatic int unsigned clamp_dim(input logic [CFG_BITS-1:0] v, input int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic pool_sample(input logic signed [15:0] s);
		int unsigned        w;
		int unsigned        h;
		int unsigned        c;
		int unsigned        r;
		int unsigned        slot;
		logic               last_col;
		logic               last_row;
		logic               emit;
		logic signed [15:0] peak;
		pooled_t            res;

		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		c = (col_idx >= w) ? w - 1 : col_idx;
		r = (row_idx >= h) ? h - 1 : row_idx;
		slot = (c >> 1) % LINE_DEPTH;
		last_col = (c == w - 1);
		last_row = (r == h - 1);
		emit = 1'b0;
		peak = '0;

		if (!c[0] || s > pair_peak)
			pair_peak = s;

		if (c[0] || last_col) begin
			if (!r[0]) begin
				if (last_row) begin
					peak = pair_peak;
					emit = 1'b1;
				end else begin
					pair_line[slot] = pair_peak;
				end
			end else begin
				peak = (pair_peak > pair_line[slot]) ? pair_peak : pair_line[slot];
				emit = 1'b1;
			end
		end

		if (last_col) begin
			col_idx = 0;
			row_idx = last_row ? 0 : r + 1;
		end else begin
			col_idx = c + 1;
			row_idx = r;
		end

		if (emit) begin
			if (peak < 0)
				peak = '0;
			res.value = peak[OUT_BITS-1:0];
			res.plane_done = last_col && last_row;
			pooled_q.push_back(res);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pooled_t exp_res;

		if (!arst_n) begin
			foreach (pair_line[i])
				pair_line[i] = '0;
			pair_peak = '0;
			col_idx = 0;
			row_idx = 0;
			width_reg = CFG_BITS'(DEF_MAX_WIDTH);
			height_reg = CFG_BITS'(MAX_HEIGHT);
			pooled_q.delete();
			err_count = 0;
			mismatches <= 0;
			awaited <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pooled_q.size() == 0) begin
					$display("%0t: unexpected output transfer, got value %0d last %0b",
						$time, m_tdata[OUT_BITS-1:0], m_tlast);
					err_count++;
				end else begin
					exp_res = pooled_q.pop_front();
					if (m_tdata[OUT_BITS-1:0] !== exp_res.value) begin
						$display("%0t: pooled_value mismatch, expected %0d got %0d",
							$time, exp_res.value, m_tdata[OUT_BITS-1:0]);
						err_count++;
					end
					if (m_tlast !== exp_res.plane_done) begin
						$display("%0t: plane_done mismatch, expected %0b got %0b",
							$time, exp_res.plane_done, m_tlast);
						err_count++;
					end
				end
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  width_reg = cfg_data;
					REG_IMAGE_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
				// any register write restarts the plane
				col_idx = 0;
				row_idx = 0;
				pair_peak = '0;
			end

			if (s_tvalid && s_tready)
				pool_sample(s_tdata);

			awaited <= pooled_q.size();
			mismatches <= err_count;
		end
	end

endmodule

// ----- dv/tb_max_pool_2x2_stream.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_pool_2x2_stream
// Stream testbench for the 2x2 max pooling block.
// Directed windows with the maximum in each tap, odd edges, zero and
// saturated plane sizes, then random plane shapes with whole and abandoned
// planes. Bursty sample traffic and a stalling receiver, including one long
// hold-off that backs up the input. The checker module does the scoring.
// ----------------------------------------------------------------------------
module tb_max_pool_2x2_stream;
	import mp2_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int IDLE_LIMIT    = 4000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 650;
	localparam int DATA_BITS     = ((DEF_SAMPLE_BITS + 7) / 8) * 8;

	typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} stall_mode_t;

	// top-right, top-left, bottom-left, bottom-right maxima
	localparam logic [15:0] CORNER_SAMPLES [16] = '{
		16'h8000, 16'h7fff, 16'hffff, 16'h0000,
		16'h4000, 16'h8000, 16'h3fff, 16'hc000,
		16'h0001, 16'h0002, 16'h0009, 16'h0004,
		16'h0010, 16'h0003, 16'h0002, 16'h0011
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [IDX_BITS-1:0]   cfg_index = '0;
	logic [CFG_BITS-1:0]   cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [DATA_BITS-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [15:0]           m_tdata;
	logic                  m_tlast;

	int unsigned mismatches;
	int unsigned awaited;
	int unsigned idle_cycles = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned plane_w = DEF_MAX_WIDTH;
	int unsigned plane_h = MAX_HEIGHT;
	bit          hold_req = 1'b0;
	bit          hold_ack = 1'b0;

	always #HALF_PERIOD clk = ~clk;

	max_pool_2x2_stream DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	max_pool_2x2_stream_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int unsigned seg;
		int unsigned k;
		stall_mode_t mode;

		forever begin
			seg = $urandom_range(16, 160);
			mode = stall_mode_t'($urandom_range(0, 3));
			k = $urandom_range(2, 7);
			repeat (seg) begin
				@(posedge clk);
				if (hold_req != hold_ack) begin
					m_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_ack = hold_req;
				end
				case (mode)
					RX_OPEN:     m_tready <= 1'b1;
					RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE:   m_tready <= ($urandom_range(0, 7) == 0);
					RX_PERIODIC: m_tready <= (($urandom % k) != 0);
					default:     m_tready <= 1'b1;
				endcase
			end
		end
	end

	function automatic int unsigned plane_extent(input int unsigned v, input int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic [15:0] pick_sample();
		int unsigned sel;

		sel = $urandom_range(0, 9);
		if (sel == 0)
			return 16'h7fff;
		if (sel == 1)
			return 16'h8000;
		if (sel < 4)
			return 16'($urandom_range(0, 8)) - 16'd4;
		return 16'($urandom);
	endfunction

	task automatic push(input logic [15:0] v);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
		end
		if (gap_left != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap_left) @(posedge clk);
			gap_left = 0;
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	// stop sending and wait for every pending pooled value
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		gap_left = 0;
		@(posedge clk);
		while (awaited != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reshape(input bit set_w, input int unsigned w,
		input bit set_h, input int unsigned h);
		drain();
		if (set_w) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_IMAGE_WIDTH;
			cfg_data <= CFG_BITS'(w);
			plane_w = plane_extent(w, DEF_MAX_WIDTH);
			@(posedge clk);
		end
		if (set_h) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_IMAGE_HEIGHT;
			cfg_data <= CFG_BITS'(h);
			plane_h = plane_extent(h, MAX_HEIGHT);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned w;
		int unsigned h;
		int unsigned n;
		int unsigned area;
		int unsigned phase;
		int unsigned random_sent;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		reshape(1'b1, 2, 1'b1, 2);
		foreach (CORNER_SAMPLES[i])
			push(CORNER_SAMPLES[i]);

		// odd right and bottom edges
		reshape(1'b1, 3, 1'b1, 3);
		repeat (9) push(pick_sample());

		// zero sizes act as one
		reshape(1'b1, 0, 1'b1, 0);
		push(16'h8000);
		push(16'h7fff);
		push(16'h0001);

		// oversize width and height clamp to the maximum, planes cut short
		reshape(1'b1, 1025, 1'b1, 2);
		repeat (8) push(pick_sample());
		reshape(1'b1, 1, 1'b1, 1025);
		repeat (8) push(pick_sample());

		phase = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
			h = $urandom_range(0, 8);
			case ((phase == 0) ? 2 : $urandom_range(0, 3))
				0:       reshape(1'b1, w, 1'b0, 0);
				1:       reshape(1'b0, 0, 1'b1, h);
				default: reshape(1'b1, w, 1'b1, h);
			endcase
			area = plane_w * plane_h;
			n = area * $urandom_range(1, 2);
			// abandoned plane, cut short by the next restart
			if ($urandom_range(0, 3) == 0)
				n += $urandom_range(0, area);
			if (phase == 0) begin
				hold_req = !hold_req;
				n += 64;
			end
			if (n > RANDOM_ITEMS - random_sent)
				n = RANDOM_ITEMS - random_sent;
			repeat (n) push(pick_sample());
			random_sent += n;
			phase++;
		end

		drain();
		if (mismatches == 0 && awaited == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
